/* rtl/svlc_pkg.sv */
// ----------------------------------------------------------------------------
// svlc_pkg
// shared types, constants and prefix tables for the identification line check
// ----------------------------------------------------------------------------
`default_nettype none

package svlc_pkg;

   localparam int unsigned CH_W     = 8;
   localparam int unsigned V2_LEN   = 8;
   localparam int unsigned V199_LEN = 9;

   localparam logic [CH_W-1:0] PRINT_LO = 8'h20;
   localparam logic [CH_W-1:0] PRINT_HI = 8'h7e;
   localparam logic [CH_W-1:0] CH_CR    = 8'h0d;
   localparam logic [CH_W-1:0] CH_LF    = 8'h0a;

   // one character of the line plus its end marker
   typedef struct packed {
      logic [CH_W-1:0] ch;
      logic            last_char;
   } svlc_item_type;

   // expected character of "SSH-2.0-" at a position
   function automatic logic [CH_W-1:0] v2_char(input logic [2:0] pos);
      logic [CH_W-1:0] c;
      case (pos)
         3'd0:    c = 8'h53; // S
         3'd1:    c = 8'h53; // S
         3'd2:    c = 8'h48; // H
         3'd3:    c = 8'h2d; // -
         3'd4:    c = 8'h32; // 2
         3'd5:    c = 8'h2e; // .
         3'd6:    c = 8'h30; // 0
         default: c = 8'h2d; // -
      endcase
      return c;
   endfunction

   // expected character of "SSH-1.99-" at a position
   function automatic logic [CH_W-1:0] v199_char(input logic [3:0] pos);
      logic [CH_W-1:0] c;
      case (pos)
         4'd0:    c = 8'h53; // S
         4'd1:    c = 8'h53; // S
         4'd2:    c = 8'h48; // H
         4'd3:    c = 8'h2d; // -
         4'd4:    c = 8'h31; // 1
         4'd5:    c = 8'h2e; // .
         4'd6:    c = 8'h39; // 9
         4'd7:    c = 8'h39; // 9
         default: c = 8'h2d; // - (and beyond the prefix, unused)
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

/* rtl/svlc_req_if.sv */
// ----------------------------------------------------------------------------
// svlc_req_if
// valid/ready channel carrying one line character per item
// ----------------------------------------------------------------------------
`default_nettype none

interface svlc_req_if
   import svlc_pkg::*;
   ();
   logic            valid;
   logic            ready;
   logic [CH_W-1:0] ch;
   logic            last_char;

   modport source (output valid, output ch, output last_char, input ready);
   modport sink   (input valid, input ch, input last_char, output ready);
endinterface

`default_nettype wire

/* rtl/svlc_rsp_if.sv */
// ----------------------------------------------------------------------------
// svlc_rsp_if
// valid/ready channel carrying one line verdict per item
// ----------------------------------------------------------------------------
`default_nettype none

interface svlc_rsp_if;
   logic valid;
   logic ready;
   logic status;

   modport source (output valid, output status, input ready);
   modport sink   (input valid, input status, output ready);
endinterface

`default_nettype wire

/* rtl/svlc_line_state.sv */
// ----------------------------------------------------------------------------
// svlc_line_state
// per-line count, prefix match and printable tracking with end-of-line verdict
// ----------------------------------------------------------------------------
`default_nettype none

module svlc_line_state
   import svlc_pkg::*;
#(
   parameter int unsigned MAX_LINE = 253
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          adv,
   input  wire svlc_item_type item,
   output logic               status
);

   localparam int unsigned CNT_W = $clog2(MAX_LINE + 2);
   localparam logic [CNT_W-1:0] CNT_SAT  = CNT_W'(MAX_LINE + 1);
   localparam logic [CNT_W-1:0] CNT_V2   = CNT_W'(V2_LEN);
   localparam logic [CNT_W-1:0] CNT_V199 = CNT_W'(V199_LEN);

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             v2_ff, v2_in;
   logic             v199_ff, v199_in;
   logic             bad_ff, bad_in;

   logic [CNT_W-1:0] len;
   logic             v2_ok, v199_ok, pfx_short;
   logic             upd_v2, upd_v199, upd_bad;

   always_comb begin
      upd_v2   = v2_ff;
      upd_v199 = v199_ff;
      if (cnt_ff < CNT_V2 && item.ch != v2_char(cnt_ff[2:0])) upd_v2 = 1'b0;
      if (cnt_ff < CNT_V199 && item.ch != v199_char(cnt_ff[3:0])) upd_v199 = 1'b0;
      upd_bad = bad_ff || item.ch < PRINT_LO || item.ch > PRINT_HI;
      len = (cnt_ff == CNT_SAT) ? cnt_ff : cnt_ff + 1'b1;

      v2_ok     = upd_v2 && len >= CNT_V2;
      v199_ok   = upd_v199 && len >= CNT_V199;
      pfx_short = v2_ok ? (len == CNT_V2) : (len == CNT_V199);

      status = (len == CNT_SAT) || item.ch == CH_CR || item.ch == CH_LF ||
               (!v2_ok && !v199_ok) || pfx_short || upd_bad;

      cnt_in  = cnt_ff;
      v2_in   = v2_ff;
      v199_in = v199_ff;
      bad_in  = bad_ff;
      if (adv) begin
         if (item.last_char) begin
            cnt_in  = '0;
            v2_in   = 1'b1;
            v199_in = 1'b1;
            bad_in  = 1'b0;
         end else begin
            cnt_in  = len;
            v2_in   = upd_v2;
            v199_in = upd_v199;
            bad_in  = upd_bad;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         v2_ff   <= 1'b1;
         v199_ff <= 1'b1;
         bad_ff  <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         v2_ff   <= v2_in;
         v199_ff <= v199_in;
         bad_ff  <= bad_in;
      end
   end

   // line state is back to reset after a final character
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (adv && item.last_char) |=> (cnt_ff == '0 && v2_ff && v199_ff && !bad_ff))
      else $error("line state not cleared after final character");

   // count never passes saturation
   a_cnt_sat: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_SAT)
      else $error("character count beyond saturation");

   // the two prefixes part at the fifth character
   a_pfx_exclusive: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff >= CNT_W'(5)) |-> !(v2_ff && v199_ff))
      else $error("both prefixes still matching past the fifth character");

endmodule

`default_nettype wire

/* rtl/ssh_version_line_check.sv */
// ----------------------------------------------------------------------------
// ssh_version_line_check
// streaming check of one protocol identification line, one character per item
// ----------------------------------------------------------------------------
// each item on req_ch is one character of an identification line (cr lf
// already removed), with last_char set on its final character. the block
// tracks length (saturating at MAX_LINE+1), match against "SSH-2.0-" and
// "SSH-1.99-", and whether any character fell outside 0x20..0x7e. on the
// final character one item goes out on rsp_ch: status 0 for an acceptable
// line, 1 for an invalid one (too long, ends in cr or lf, no prefix, nothing
// after the prefix, or a non-printable character). other characters give no
// output. one character per cycle, unless a final character waits behind
// a verdict held on rsp_ch. a final character passes the input register,
// then the per-line state update and verdict logic feed the output register.
// a waiting verdict stalls only the next final character, not ordinary ones.
// ----------------------------------------------------------------------------
`default_nettype none

module ssh_version_line_check
   import svlc_pkg::*;
#(
   parameter int unsigned MAX_LINE = 253
) (
   input  wire logic   clock,
   input  wire logic   reset,
   svlc_req_if.sink    req_ch,
   svlc_rsp_if.source  rsp_ch
);

   // input register stage
   logic          s1_vld_ff, s1_vld_in;
   svlc_item_type s1_item_ff, s1_item_in;
   logic          s1_adv;

   // output register
   logic          rsp_vld_ff, rsp_vld_in;
   logic          rsp_status_ff, rsp_status_in;

   logic          out_free;
   logic          verdict;

   // output slot is free when empty or being drained this cycle
   assign out_free = !rsp_vld_ff || rsp_ch.ready;
   // non-final characters never need the output slot
   assign s1_adv   = s1_vld_ff && (!s1_item_ff.last_char || out_free);
   assign req_ch.ready = !s1_vld_ff || s1_adv;

   always_comb begin
      s1_vld_in  = s1_vld_ff;
      s1_item_in = s1_item_ff;
      if (req_ch.ready) begin
         s1_vld_in            = req_ch.valid;
         s1_item_in.ch        = req_ch.ch;
         s1_item_in.last_char = req_ch.last_char;
      end

      rsp_vld_in    = rsp_vld_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      if (s1_adv && s1_item_ff.last_char) begin
         rsp_vld_in    = 1'b1;
         rsp_status_in = verdict;
      end
   end

   svlc_line_state #(
      .MAX_LINE (MAX_LINE)
   ) u_state (
      .clock  (clock),
      .reset  (reset),
      .adv    (s1_adv),
      .item   (s1_item_ff),
      .status (verdict)
   );

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      s1_item_ff    <= s1_item_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   assign rsp_ch.valid  = rsp_vld_ff;
   assign rsp_ch.status = rsp_status_ff;

   // a final character that moves on always produces a verdict next cycle
   a_verdict_follows: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_item_ff.last_char) |=> rsp_vld_ff)
      else $error("final character advanced without a verdict");

   // a final character must hold while the verdict slot is blocked
   a_last_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && !rsp_ch.ready && s1_vld_ff && s1_item_ff.last_char) |-> !s1_adv)
      else $error("final character advanced over a pending verdict");

   // a non-final character in the input stage never stalls
   a_plain_flows: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && !s1_item_ff.last_char) |-> s1_adv)
      else $error("ordinary character stalled");

endmodule

`default_nettype wire
